// File: sv/adc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types, constants and helpers of the access decision cache.
// ----------------------------------------------------------------------------
package adc_pkg;

    // Geometry (BUCKETS is a power of two)
    localparam int BUCKETS       = 512;
    localparam int WAYS          = 4;
    localparam int RECLAIM_BATCH = 16;

    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BATCH_W  = $clog2(RECLAIM_BATCH + 1);
    localparam int TRY_W    = $clog2(BUCKETS + 1);
    localparam int CLR_W    = $clog2(WAYS + 1);
    localparam int COUNT_W  = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_ENFORCING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;
    localparam logic [COUNT_W-1:0]   THRESHOLD_RST = 12'd512;

    // Operations
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    // Update events
    localparam logic [2:0] EV_GRANT     = 3'd0;
    localparam logic [2:0] EV_REVOKE    = 3'd1;
    localparam logic [2:0] EV_AUDA_ON   = 3'd2;
    localparam logic [2:0] EV_AUDA_OFF  = 3'd3;
    localparam logic [2:0] EV_AUDD_ON   = 3'd4;
    localparam logic [2:0] EV_AUDD_OFF  = 3'd5;

    // Result status
    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_DENIED = 3'd1;
    localparam logic [2:0] STS_MISS   = 3'd2;
    localparam logic [2:0] STS_STALE  = 3'd3;
    localparam logic [2:0] STS_ABSENT = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] source_id;
        logic [31:0] target_id;
        logic [15:0] object_class;
        logic [31:0] perm_bits;
        logic [2:0]  update_event;
        logic [31:0] new_allowed;
        logic [31:0] new_audit_allow;
        logic [31:0] new_audit_deny;
        logic [31:0] sequence_req;
        logic        new_permissive;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               hit;
        logic [31:0]        allowed_out;
        logic [31:0]        audit_allow_out;
        logic [31:0]        audit_deny_out;
        logic [31:0]        entry_sequence_out;
        logic               permissive_out;
        logic [COUNT_W-1:0] live_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] target;
        logic [15:0] cls;
        logic [31:0] allowed;
        logic [31:0] audit_allow;
        logic [31:0] audit_deny;
        logic [31:0] seq_num;
        logic        permissive;
    } entry_t;

    typedef struct packed {
        logic [WAYS-1:0]            valid;
        entry_t [WAYS-1:0]          way;
    } row_t;

    typedef struct packed {
        logic                rd_en;
        logic [BUCKET_W-1:0] rd_addr;
        logic                wr_en;
        logic [BUCKET_W-1:0] wr_addr;
        row_t                wr_row;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RC_READ,
        S_RC_WRITE,
        S_LOOKUP,
        S_EXEC
    } state_t;

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [31:0] src,
                                                      input logic [31:0] tgt,
                                                      input logic [15:0] cls);
        logic [31:0] h;
        h = src ^ (tgt << 2) ^ ({16'b0, cls} << 4);
        return h[BUCKET_W-1:0];
    endfunction

endpackage

// File: sv/adc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_req_if / adc_rsp_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface adc_req_if
    import adc_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface adc_rsp_if
    import adc_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/adc_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_row_mem
// Bucket store: one row per bucket holding all ways and their valid bits.
// ----------------------------------------------------------------------------
module adc_row_mem
    import adc_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mreq,
    output row_t     rd_row
);

    row_t mem [BUCKETS];
    row_t rd_row_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_row;
        end
    end

    // Registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (mreq.rd_en)
        begin
            rd_row_reg <= mem[mreq.rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

// File: sv/adc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ctrl
// Sequencer and datapath: lookup, read-modify-write, reclaim walk, clearing.
// ----------------------------------------------------------------------------
module adc_ctrl
    import adc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    adc_req_if.sink               req,
    adc_rsp_if.source             rsp,
    output mem_req_t              mreq,
    input  row_t                  rd_row
);

    state_t state_reg, state_next;

    req_t                item_reg, item_next;
    rsp_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                enforcing_reg, enforcing_next;
    logic [COUNT_W-1:0]  threshold_reg, threshold_next;
    logic [31:0]         notice_reg, notice_next;
    logic [BUCKET_W-1:0] cursor_reg, cursor_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [BATCH_W-1:0]  got_reg, got_next;
    logic [TRY_W-1:0]    tries_reg, tries_next;
    logic [BUCKET_W-1:0] clr_reg, clr_next;

    logic                accept;
    logic                out_free;
    logic                need_reclaim;
    logic                stale;
    logic [BUCKET_W-1:0] cursor_inc;
    logic [WAYS-1:0]     match;
    logic                match_any;
    logic [WAY_W-1:0]    mw;
    logic [WAY_W-1:0]    fw;
    logic [WAY_W-1:0]    tw;
    entry_t              sel;
    entry_t              new_entry;
    logic [31:0]         denied;
    logic [WAYS-1:0]     rc_valid;
    logic [BATCH_W-1:0]  rc_got;
    logic [CLR_W-1:0]    rc_cleared;
    logic                rc_done;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign stale    = (item_reg.sequence_req < notice_reg);
    assign need_reclaim = (req.payload.operation == OP_FILL)
        && !(req.payload.sequence_req < notice_reg)
        && ({1'b0, count_reg} + 13'd1 > {1'b0, threshold_reg});
    assign cursor_inc = (cursor_reg == BUCKET_W'(BUCKETS - 1)) ? '0
                                                                : cursor_reg + 1'b1;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    // Match the item's key against every way of the row
    always_comb
    begin
        match_any = 1'b0;
        mw = '0;
        fw = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            match[w] = rd_row.valid[w]
                && rd_row.way[w].source == item_reg.source_id
                && rd_row.way[w].target == item_reg.target_id
                && rd_row.way[w].cls == item_reg.object_class;
            if (match[w])
            begin
                mw = WAY_W'(w);
            end
            if (!rd_row.valid[w])
            begin
                fw = WAY_W'(w);
            end
        end
        match_any = |match;
        tw = match_any ? mw : fw;
        sel = rd_row.way[mw];
        denied = item_reg.perm_bits & ~sel.allowed;
        new_entry.source      = item_reg.source_id;
        new_entry.target      = item_reg.target_id;
        new_entry.cls         = item_reg.object_class;
        new_entry.allowed     = item_reg.new_allowed;
        new_entry.audit_allow = item_reg.new_audit_allow;
        new_entry.audit_deny  = item_reg.new_audit_deny;
        new_entry.seq_num     = item_reg.sequence_req;
        new_entry.permissive  = item_reg.new_permissive;
    end

    // Clear ways of the reclaimed row in ascending order up to the batch size
    always_comb
    begin
        rc_valid = rd_row.valid;
        rc_got = got_reg;
        rc_cleared = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rc_valid[w] && rc_got < BATCH_W'(RECLAIM_BATCH))
            begin
                rc_valid[w] = 1'b0;
                rc_got = rc_got + 1'b1;
                rc_cleared = rc_cleared + 1'b1;
            end
        end
        rc_done = (rc_got >= BATCH_W'(RECLAIM_BATCH))
            || (tries_reg == TRY_W'(BUCKETS));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == BUCKET_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_reclaim ? S_RC_READ : S_EXEC;
                end
            end
            S_RC_READ:
            begin
                state_next = S_RC_WRITE;
            end
            S_RC_WRITE:
            begin
                state_next = rc_done ? S_LOOKUP : S_RC_READ;
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = (item_reg.operation == OP_FLUSH) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and result
    always_comb
    begin
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        enforcing_next = enforcing_reg;
        threshold_next = threshold_reg;
        notice_next    = notice_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        got_next       = got_reg;
        tries_next     = tries_reg;
        clr_next       = clr_reg;
        mreq.rd_en     = 1'b0;
        mreq.rd_addr   = bucket_of(item_reg.source_id, item_reg.target_id,
                                   item_reg.object_class);
        mreq.wr_en     = 1'b0;
        mreq.wr_addr   = mreq.rd_addr;
        mreq.wr_row    = rd_row;

        // Drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENFORCING: enforcing_next = cfg_wdata[0];
                CFG_THRESHOLD: threshold_next = cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = clr_reg;
                mreq.wr_row.valid = '0;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = req.payload;
                    mreq.rd_en = 1'b1;
                    mreq.rd_addr = bucket_of(req.payload.source_id,
                                             req.payload.target_id,
                                             req.payload.object_class);
                    got_next = '0;
                    tries_next = '0;
                end
            end
            S_RC_READ:
            begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = cursor_inc;
                cursor_next = cursor_inc;
                tries_next = tries_reg + 1'b1;
            end
            S_RC_WRITE:
            begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = cursor_reg;
                mreq.wr_row.valid = rc_valid;
                got_next = rc_got;
                count_next = count_reg - COUNT_W'(rc_cleared);
            end
            S_LOOKUP:
            begin
                mreq.rd_en = 1'b1;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    case (item_reg.operation)
                        OP_CHECK:
                        begin
                            if (!match_any)
                            begin
                                out_next.status = STS_MISS;
                            end
                            else
                            begin
                                out_next.hit = 1'b1;
                                out_next.allowed_out = sel.allowed;
                                out_next.audit_allow_out = sel.audit_allow;
                                out_next.audit_deny_out = sel.audit_deny;
                                out_next.entry_sequence_out = sel.seq_num;
                                out_next.permissive_out = sel.permissive;
                                if (denied != '0)
                                begin
                                    if (!enforcing_reg || sel.permissive)
                                    begin
                                        mreq.wr_en = 1'b1;
                                        mreq.wr_row.way[mw].allowed =
                                            sel.allowed | item_reg.perm_bits;
                                    end
                                    else
                                    begin
                                        out_next.status = STS_DENIED;
                                    end
                                end
                            end
                        end
                        OP_FILL:
                        begin
                            if (stale)
                            begin
                                out_next.status = STS_STALE;
                            end
                            else
                            begin
                                mreq.wr_en = 1'b1;
                                mreq.wr_row.valid[tw] = 1'b1;
                                mreq.wr_row.way[tw] = new_entry;
                                if (!match_any && !rd_row.valid[tw])
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                                out_next.hit = match_any;
                                out_next.allowed_out = new_entry.allowed;
                                out_next.audit_allow_out = new_entry.audit_allow;
                                out_next.audit_deny_out = new_entry.audit_deny;
                                out_next.entry_sequence_out = new_entry.seq_num;
                                out_next.permissive_out = new_entry.permissive;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (!match_any || sel.seq_num != item_reg.sequence_req)
                            begin
                                out_next.status = STS_ABSENT;
                            end
                            else
                            begin
                                out_next.hit = 1'b1;
                                out_next.allowed_out = sel.allowed;
                                out_next.audit_allow_out = sel.audit_allow;
                                out_next.audit_deny_out = sel.audit_deny;
                                out_next.entry_sequence_out = sel.seq_num;
                                out_next.permissive_out = sel.permissive;
                                mreq.wr_en = 1'b1;
                                case (item_reg.update_event)
                                    EV_GRANT: mreq.wr_row.way[mw].allowed =
                                        sel.allowed | item_reg.perm_bits;
                                    EV_REVOKE: mreq.wr_row.way[mw].allowed =
                                        sel.allowed & ~item_reg.perm_bits;
                                    EV_AUDA_ON: mreq.wr_row.way[mw].audit_allow =
                                        sel.audit_allow | item_reg.perm_bits;
                                    EV_AUDA_OFF: mreq.wr_row.way[mw].audit_allow =
                                        sel.audit_allow & ~item_reg.perm_bits;
                                    EV_AUDD_ON: mreq.wr_row.way[mw].audit_deny =
                                        sel.audit_deny | item_reg.perm_bits;
                                    EV_AUDD_OFF: mreq.wr_row.way[mw].audit_deny =
                                        sel.audit_deny & ~item_reg.perm_bits;
                                    default: mreq.wr_en = 1'b0;
                                endcase
                            end
                        end
                        default:
                        begin
                            // Flush: invalidate everything via the clearing pass
                            count_next = '0;
                            clr_next = '0;
                            if (item_reg.sequence_req > notice_reg)
                            begin
                                notice_next = item_reg.sequence_req;
                            end
                        end
                    endcase
                    out_next.live_count = count_next;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            enforcing_reg <= 1'b1;
            threshold_reg <= THRESHOLD_RST;
            notice_reg    <= '0;
            cursor_reg    <= '0;
            count_reg     <= '0;
            got_reg       <= '0;
            tries_reg     <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            enforcing_reg <= enforcing_next;
            threshold_reg <= threshold_next;
            notice_reg    <= notice_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            got_reg       <= got_next;
            tries_reg     <= tries_next;
            clr_reg       <= clr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

endmodule

// File: sv/access_decision_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_decision_cache
// Hashed set-associative cache of permission decisions.
//
//   Channel  Dir  Handshake     Carries
//   req      in   valid/ready   operation, key, masks, fill vectors, sequence
//   rsp      out  valid/ready   status, hit, entry fields, live count
//   cfg      in   write enable  enforcing, fill threshold
//
// Check, update and plain fill read one bucket row, then compare and write
// back. A fill that triggers reclaim first reads and writes back each bucket
// walked (up to BUCKETS), then re-reads its own row. Flush adds a clearing
// pass over all buckets; after reset the same pass runs with req not ready.
// A result waits in the output register; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module access_decision_cache
    import adc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    adc_req_if.sink               req,
    adc_rsp_if.source             rsp
);

    mem_req_t mreq;
    row_t     rd_row;

    // Bucket store
    adc_row_mem u_mem (
        .clk    (clk),
        .mreq   (mreq),
        .rd_row (rd_row)
    );

    // Sequencer
    adc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .mreq      (mreq),
        .rd_row    (rd_row)
    );

endmodule
